[rtl/swhs_pkg.sv]
// Shared types and constants for the single-wire humidity sensor reader.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package swhs_pkg;

    localparam int FRAME_BITS_DEF = 40;
    localparam int CHK_W          = 40;
    localparam int IN_W           = 8;
    localparam int OUT_W          = 40;
    localparam int ADDR_W         = 5;
    localparam int DATA_W         = 32;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_WAKE  = 3'd1;
    localparam logic [2:0] PH_START = 3'd2;
    localparam logic [2:0] PH_REL   = 3'd3;
    localparam logic [2:0] PH_SKIP  = 3'd4;
    localparam logic [2:0] PH_BITS  = 3'd5;

    localparam logic [1:0] ST_GOOD    = 2'd0;
    localparam logic [1:0] ST_CHKSUM  = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    localparam logic [2:0] REG_WAKE    = 3'd0;
    localparam logic [2:0] REG_START   = 3'd1;
    localparam logic [2:0] REG_RELEASE = 3'd2;
    localparam logic [2:0] REG_ONE     = 3'd3;
    localparam logic [2:0] REG_TIMEOUT = 3'd4;

    localparam logic [19:0] WAKE_RST    = 20'd800000;
    localparam logic [15:0] START_RST   = 16'd18000;
    localparam logic [7:0]  RELEASE_RST = 8'd30;
    localparam logic [7:0]  ONE_RST     = 8'd28;
    localparam logic [7:0]  TIMEOUT_RST = 8'd70;

    typedef struct packed {
        logic [19:0] wake_high_ticks;
        logic [15:0] start_low_ticks;
        logic [7:0]  release_high_ticks;
        logic [7:0]  one_threshold;
        logic [7:0]  timeout_threshold;
    } cfg_t;

    // packed from drive_enable in bit 0 upward
    typedef struct packed {
        logic [1:0] pad;
        logic [7:0] temp_frac;
        logic [7:0] temp_int;
        logic [7:0] humidity_frac;
        logic [7:0] humidity_int;
        logic [1:0] status;
        logic       frame_done;
        logic       busy_res;
        logic       drive_level;
        logic       drive_enable;
    } res_t;

endpackage

[rtl/swhs_cfg.sv]
// APB register file holding the drive timings and pulse thresholds.
// Depends on swhs_pkg.
`timescale 1ns / 1ps

module swhs_cfg
    import swhs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wake_high_ticks    <= WAKE_RST;
            cfg_reg.start_low_ticks    <= START_RST;
            cfg_reg.release_high_ticks <= RELEASE_RST;
            cfg_reg.one_threshold      <= ONE_RST;
            cfg_reg.timeout_threshold  <= TIMEOUT_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_WAKE:    cfg_reg.wake_high_ticks    <= pwdata[19:0];
                REG_START:   cfg_reg.start_low_ticks    <= pwdata[15:0];
                REG_RELEASE: cfg_reg.release_high_ticks <= pwdata[7:0];
                REG_ONE:     cfg_reg.one_threshold      <= pwdata[7:0];
                REG_TIMEOUT: cfg_reg.timeout_threshold  <= pwdata[7:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_WAKE:    prdata = {12'd0, cfg_reg.wake_high_ticks};
            REG_START:   prdata = {16'd0, cfg_reg.start_low_ticks};
            REG_RELEASE: prdata = {24'd0, cfg_reg.release_high_ticks};
            REG_ONE:     prdata = {24'd0, cfg_reg.one_threshold};
            REG_TIMEOUT: prdata = {24'd0, cfg_reg.timeout_threshold};
            default:     prdata = '0;
        endcase
    end

endmodule

[rtl/swhs_core.sv]
// Frame sequencer: drive phases, run skipping, pulse timing and checksum.
// Depends on swhs_pkg; one tick word is processed per accepted cycle.
`timescale 1ns / 1ps

module swhs_core
    import swhs_pkg::*;
#(
    parameter int FRAME_BITS = FRAME_BITS_DEF
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  tick_en,
    input  logic  start_req,
    input  logic  line_level,
    input  cfg_t  cfg,
    output res_t  res
);

    localparam int BC_W = $clog2(FRAME_BITS + 1);

    logic [2:0]            phase_reg, phase_next;
    logic [19:0]           tick_count_reg, tick_count_next;
    logic [7:0]            high_width_reg, high_width_next;
    logic [1:0]            runs_skipped_reg, runs_skipped_next;
    logic [BC_W-1:0]       bit_count_reg, bit_count_next;
    logic [FRAME_BITS-1:0] shift_bits_reg, shift_bits_next;
    logic                  prev_level_reg, prev_level_next;
    logic [31:0]           result_bytes_reg, result_bytes_next;
    logic [1:0]            last_status_reg, last_status_next;

    logic [20:0]           tick_inc;
    logic [7:0]            width_inc;
    logic [BC_W:0]         bit_inc;
    logic                  bit_val;
    logic [FRAME_BITS-1:0] shift_cat;
    logic [CHK_W-1:0]      frame_v;
    logic [7:0]            sum8;
    logic                  done;

    assign tick_inc  = {1'b0, tick_count_reg} + 21'd1;
    assign width_inc = (high_width_reg == 8'hFF) ? high_width_reg : high_width_reg + 8'd1;
    assign bit_inc   = {1'b0, bit_count_reg} + (BC_W+1)'(1);
    assign bit_val   = high_width_reg > cfg.one_threshold;
    assign shift_cat = {shift_bits_reg[FRAME_BITS-2:0], bit_val};

    generate
        if (FRAME_BITS >= CHK_W)
        begin : g_wide
            assign frame_v = shift_cat[CHK_W-1:0];
        end
        else
        begin : g_narrow
            assign frame_v = {(CHK_W-FRAME_BITS)'(0), shift_cat};
        end
    endgenerate

    assign sum8 = frame_v[39:32] + frame_v[31:24] + frame_v[23:16] + frame_v[15:8];

    always_comb
    begin
        phase_next        = phase_reg;
        tick_count_next   = tick_count_reg;
        high_width_next   = high_width_reg;
        runs_skipped_next = runs_skipped_reg;
        bit_count_next    = bit_count_reg;
        shift_bits_next   = shift_bits_reg;
        prev_level_next   = prev_level_reg;
        result_bytes_next = result_bytes_reg;
        last_status_next  = last_status_reg;
        done              = 1'b0;

        case (phase_reg)
            PH_WAKE:
            begin
                tick_count_next = tick_inc[19:0];
                if (tick_inc >= {1'b0, cfg.wake_high_ticks})
                begin
                    phase_next      = PH_START;
                    tick_count_next = '0;
                end
            end
            PH_START:
            begin
                tick_count_next = tick_inc[19:0];
                if (tick_inc >= 21'(cfg.start_low_ticks))
                begin
                    phase_next      = PH_REL;
                    tick_count_next = '0;
                end
            end
            PH_REL:
            begin
                tick_count_next = tick_inc[19:0];
                if (tick_inc >= 21'(cfg.release_high_ticks))
                begin
                    phase_next      = PH_SKIP;
                    tick_count_next = '0;
                end
            end
            PH_SKIP:
            begin
                if (tick_count_reg == 20'd0)
                begin
                    prev_level_next = line_level;
                    tick_count_next = 20'd1;
                end
                else if (line_level != prev_level_reg)
                begin
                    prev_level_next   = line_level;
                    runs_skipped_next = runs_skipped_reg + 2'd1;
                    if (runs_skipped_reg == 2'd2)
                    begin
                        phase_next      = PH_BITS;
                        high_width_next = {7'd0, line_level};
                        if ({7'd0, line_level} > cfg.timeout_threshold)
                        begin
                            phase_next       = PH_IDLE;
                            last_status_next = ST_TIMEOUT;
                            done             = 1'b1;
                        end
                    end
                end
            end
            PH_BITS:
            begin
                prev_level_next = line_level;
                if (line_level)
                begin
                    high_width_next = width_inc;
                    if (width_inc > cfg.timeout_threshold)
                    begin
                        phase_next       = PH_IDLE;
                        last_status_next = ST_TIMEOUT;
                        done             = 1'b1;
                    end
                end
                else if (high_width_reg != 8'd0)
                begin
                    shift_bits_next = shift_cat;
                    high_width_next = '0;
                    bit_count_next  = bit_inc[BC_W-1:0];
                    if (bit_inc >= (BC_W+1)'(FRAME_BITS))
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                        if (sum8 == frame_v[7:0])
                        begin
                            result_bytes_next = frame_v[39:8];
                            last_status_next  = ST_GOOD;
                        end
                        else
                        begin
                            last_status_next = ST_CHKSUM;
                        end
                    end
                end
            end
            default:
            begin
                // idle, and any stray code
                phase_next = PH_IDLE;
                if (start_req)
                begin
                    phase_next        = PH_WAKE;
                    tick_count_next   = '0;
                    high_width_next   = '0;
                    runs_skipped_next = '0;
                    bit_count_next    = '0;
                    shift_bits_next   = '0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            tick_count_reg   <= '0;
            high_width_reg   <= '0;
            runs_skipped_reg <= '0;
            bit_count_reg    <= '0;
            shift_bits_reg   <= '0;
            prev_level_reg   <= 1'b1;
            result_bytes_reg <= '0;
            last_status_reg  <= ST_GOOD;
        end
        else if (tick_en)
        begin
            phase_reg        <= phase_next;
            tick_count_reg   <= tick_count_next;
            high_width_reg   <= high_width_next;
            runs_skipped_reg <= runs_skipped_next;
            bit_count_reg    <= bit_count_next;
            shift_bits_reg   <= shift_bits_next;
            prev_level_reg   <= prev_level_next;
            result_bytes_reg <= result_bytes_next;
            last_status_reg  <= last_status_next;
        end
    end

    always_comb
    begin
        res               = '0;
        res.drive_enable  = (phase_next == PH_WAKE) || (phase_next == PH_START)
                            || (phase_next == PH_REL);
        res.drive_level   = (phase_next == PH_WAKE) || (phase_next == PH_REL);
        res.busy_res      = phase_next != PH_IDLE;
        res.frame_done    = done;
        res.status        = last_status_next;
        res.humidity_int  = result_bytes_next[31:24];
        res.humidity_frac = result_bytes_next[23:16];
        res.temp_int      = result_bytes_next[15:8];
        res.temp_frac     = result_bytes_next[7:0];
    end

endmodule

[rtl/swhs_outbuf.sv]
// Result register with a skid stage that holds one further word under stall.
// Depends on swhs_pkg for the result word type.
`timescale 1ns / 1ps

module swhs_outbuf
    import swhs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_push,
    input  res_t in_word,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_word
);

    logic out_valid_reg;
    res_t out_word_reg;
    logic skid_valid_reg;
    res_t skid_word_reg;
    logic out_free;

    assign in_ready  = ~skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_free  = out_ready | ~out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg | in_push;
            skid_valid_reg <= 1'b0;
        end
        else if (in_push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_word_reg <= skid_valid_reg ? skid_word_reg : in_word;
        end
        else if (in_push)
        begin
            skid_word_reg <= in_word;
        end
    end

endmodule

[rtl/single_wire_humidity_sensor_reader.sv]
// Top level of the single-wire humidity sensor reader.
// Depends on swhs_pkg, swhs_cfg, swhs_core and swhs_outbuf.
`timescale 1ns / 1ps
//
// Usage:
//  s_* channel: one word per 1 us tick, carrying the start request and the
//  sampled line level. m_* channel: one result word per tick word, carrying
//  drive enable/level for the line pad, busy, frame-done pulse, status and
//  the four bytes of the last good frame.
//  The result word is formed from the accepted tick word and then registered;
//  one tick word is taken every cycle while s_tready is high.
//  The APB port sets the drive timings and pulse thresholds; write it only
//  while no frame is in progress.
//  Reset returns the sequencer to idle with the line released, clears the
//  status and data bytes and loads the default timings.
//  When the receiver stalls, one further tick word is held in the skid
//  stage, after which s_tready drops until the result register drains.
//
module single_wire_humidity_sensor_reader
    import swhs_pkg::*;
#(
    parameter int FRAME_BITS = FRAME_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,  // start_req, line_level, zero fill
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,  // drive_enable, drive_level, busy_res,
                                        // frame_done, status[1:0], humidity_int,
                                        // humidity_frac, temp_int, temp_frac, zero fill
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t cfg;
    res_t core_res;
    res_t out_res;
    logic tick_en;

    assign tick_en = s_tvalid & s_tready;
    assign m_tdata = out_res;

    swhs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    swhs_core #(
        .FRAME_BITS (FRAME_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_en    (tick_en),
        .start_req  (s_tdata[0]),
        .line_level (s_tdata[1]),
        .cfg        (cfg),
        .res        (core_res)
    );

    swhs_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_push   (tick_en),
        .in_word   (core_res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (out_res)
    );

endmodule

[rtl/swhs_checker.sv]
// Port-level checks on the reader's result stream and handshakes.
// Depends on swhs_pkg; bound to single_wire_humidity_sensor_reader.
`timescale 1ns / 1ps

module swhs_checker
    import swhs_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> !m_tdata[2])
        else $error("frame done while still busy");

    a_level_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1] |-> m_tdata[0] && m_tdata[2])
        else $error("line driven high outside a drive phase");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[5:4] != 2'd3)
        else $error("unused status code");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

endmodule

bind single_wire_humidity_sensor_reader swhs_checker u_swhs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[verif/swhs_frame_checker.sv]
// Frame checker for the single-wire humidity sensor reader: predicts every result word
// from the tick words and APB writes it sees, then compares each result field by field.
// Depends on swhs_pkg.
`timescale 1ns / 1ps

module swhs_frame_checker
    import swhs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // start_req, line_level, zero fill
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [OUT_W-1:0]  m_tdata,   // drive_enable, drive_level, busy_res, frame_done,
                                         // status[1:0], humidity_int, humidity_frac,
                                         // temp_int, temp_frac, zero fill
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              pready,
    output int                errors,
    output int                words_due,
    output logic              reader_busy,
    output int                ticks,
    output int                n_good,
    output int                n_chksum,
    output int                n_timeout
);

    cfg_t        timing;
    logic [2:0]  seq_phase;
    logic [19:0] tick_cnt;
    logic [7:0]  pulse_w;
    logic [1:0]  runs_seen;
    logic [5:0]  bits_seen;
    logic [39:0] frame_bits;
    logic        prev_lv;
    logic [31:0] data_bytes;
    logic [1:0]  last_st;
    res_t        predicted_words[$];

    int err_cnt   = 0;
    int tick_cnt_total = 0;
    int good_cnt  = 0;
    int chk_cnt   = 0;
    int tmo_cnt   = 0;

    assign errors    = err_cnt;
    assign ticks     = tick_cnt_total;
    assign n_good    = good_cnt;
    assign n_chksum  = chk_cnt;
    assign n_timeout = tmo_cnt;

    task automatic report_mismatch(input string what);
        if (err_cnt < 20)
            $display("%0d ns  mismatch: %s", $time, what);
        err_cnt++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    function automatic res_t step_reader(input logic req, input logic lv);
        res_t       r;
        logic       done;
        logic [7:0] sum;
        done = 1'b0;
        if (seq_phase > PH_BITS)
            seq_phase = PH_IDLE;
        case (seq_phase)
            PH_IDLE:
            begin
                if (req)
                begin
                    seq_phase  = PH_WAKE;
                    tick_cnt   = '0;
                    pulse_w    = '0;
                    runs_seen  = '0;
                    bits_seen  = '0;
                    frame_bits = '0;
                end
            end
            PH_WAKE:
            begin
                if ({1'b0, tick_cnt} + 21'd1 >= {1'b0, timing.wake_high_ticks})
                begin
                    seq_phase = PH_START;
                    tick_cnt  = '0;
                end
                else
                    tick_cnt = tick_cnt + 20'd1;
            end
            PH_START:
            begin
                if ({1'b0, tick_cnt} + 21'd1 >= {5'd0, timing.start_low_ticks})
                begin
                    seq_phase = PH_REL;
                    tick_cnt  = '0;
                end
                else
                    tick_cnt = tick_cnt + 20'd1;
            end
            PH_REL:
            begin
                if ({1'b0, tick_cnt} + 21'd1 >= {13'd0, timing.release_high_ticks})
                begin
                    seq_phase = PH_SKIP;
                    tick_cnt  = '0;
                end
                else
                    tick_cnt = tick_cnt + 20'd1;
            end
            PH_SKIP:
            begin
                if (tick_cnt == '0)
                begin
                    prev_lv  = lv;
                    tick_cnt = 20'd1;
                end
                else if (lv != prev_lv)
                begin
                    prev_lv   = lv;
                    runs_seen = runs_seen + 2'd1;
                    if (runs_seen == 2'd3)
                    begin
                        seq_phase = PH_BITS;
                        pulse_w   = {7'd0, lv};
                        if (pulse_w > timing.timeout_threshold)
                        begin
                            seq_phase = PH_IDLE;
                            last_st   = ST_TIMEOUT;
                            done      = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                prev_lv = lv;
                if (lv)
                begin
                    if (pulse_w != 8'hFF)
                        pulse_w = pulse_w + 8'd1;
                    if (pulse_w > timing.timeout_threshold)
                    begin
                        seq_phase = PH_IDLE;
                        last_st   = ST_TIMEOUT;
                        done      = 1'b1;
                    end
                end
                else if (pulse_w != '0)
                begin
                    frame_bits = {frame_bits[38:0], pulse_w > timing.one_threshold};
                    pulse_w    = '0;
                    bits_seen  = bits_seen + 6'd1;
                    if (int'(bits_seen) >= FRAME_BITS_DEF)
                    begin
                        sum = frame_bits[39:32] + frame_bits[31:24] + frame_bits[23:16]
                            + frame_bits[15:8];
                        if (sum == frame_bits[7:0])
                        begin
                            data_bytes = frame_bits[39:8];
                            last_st    = ST_GOOD;
                        end
                        else
                            last_st = ST_CHKSUM;
                        seq_phase = PH_IDLE;
                        done      = 1'b1;
                    end
                end
            end
        endcase

        if (done)
        begin
            if (last_st == ST_GOOD)
                good_cnt++;
            else if (last_st == ST_CHKSUM)
                chk_cnt++;
            else
                tmo_cnt++;
        end

        r               = '0;
        r.drive_enable  = (seq_phase == PH_WAKE) || (seq_phase == PH_START)
                        || (seq_phase == PH_REL);
        r.drive_level   = (seq_phase == PH_WAKE) || (seq_phase == PH_REL);
        r.busy_res      = (seq_phase != PH_IDLE);
        r.frame_done    = done;
        r.status        = last_st;
        r.humidity_int  = data_bytes[31:24];
        r.humidity_frac = data_bytes[23:16];
        r.temp_int      = data_bytes[15:8];
        r.temp_frac     = data_bytes[7:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t got;
        res_t want;
        if (!rst_n)
        begin
            timing.wake_high_ticks    = WAKE_RST;
            timing.start_low_ticks    = START_RST;
            timing.release_high_ticks = RELEASE_RST;
            timing.one_threshold      = ONE_RST;
            timing.timeout_threshold  = TIMEOUT_RST;
            seq_phase  = PH_IDLE;
            tick_cnt   = '0;
            pulse_w    = '0;
            runs_seen  = '0;
            bits_seen  = '0;
            frame_bits = '0;
            prev_lv    = 1'b1;
            data_bytes = '0;
            last_st    = ST_GOOD;
            predicted_words.delete();
            words_due   <= 0;
            reader_busy <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = res_t'(m_tdata);
                if (predicted_words.size() == 0)
                    report_mismatch("result word with nothing expected");
                else
                begin
                    want = predicted_words.pop_front();
                    check_field("drive_enable", int'(got.drive_enable),
                                int'(want.drive_enable));
                    check_field("drive_level", int'(got.drive_level),
                                int'(want.drive_level));
                    check_field("busy_res", int'(got.busy_res), int'(want.busy_res));
                    check_field("frame_done", int'(got.frame_done), int'(want.frame_done));
                    check_field("status", int'(got.status), int'(want.status));
                    check_field("humidity_int", int'(got.humidity_int),
                                int'(want.humidity_int));
                    check_field("humidity_frac", int'(got.humidity_frac),
                                int'(want.humidity_frac));
                    check_field("temp_int", int'(got.temp_int), int'(want.temp_int));
                    check_field("temp_frac", int'(got.temp_frac), int'(want.temp_frac));
                end
            end

            if (psel && penable && pwrite && pready)
            begin
                case (paddr[ADDR_W-1:2])
                    REG_WAKE:    timing.wake_high_ticks    = pwdata[19:0];
                    REG_START:   timing.start_low_ticks    = pwdata[15:0];
                    REG_RELEASE: timing.release_high_ticks = pwdata[7:0];
                    REG_ONE:     timing.one_threshold      = pwdata[7:0];
                    REG_TIMEOUT: timing.timeout_threshold  = pwdata[7:0];
                    default:     ;
                endcase
            end

            if (s_tvalid && s_tready)
            begin
                predicted_words.push_back(step_reader(s_tdata[0], s_tdata[1]));
                tick_cnt_total++;
            end

            words_due   <= predicted_words.size();
            reader_busy <= (seq_phase != PH_IDLE);
        end
    end

endmodule

[verif/tb_single_wire_humidity_sensor_reader.sv]
// Testbench top for the single-wire humidity sensor reader: drives tick words, sensor
// frames and APB timing setups, and gives the verdict from swhs_frame_checker.
// Depends on swhs_pkg, swhs_frame_checker and the reader RTL.
`timescale 1ns / 1ps

module tb_single_wire_humidity_sensor_reader;
    import swhs_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_TICKS = 60;
    localparam int LONG_HOLD   = 300;
    localparam int NO_BIT      = -1;

    logic              clk      = 1'b0;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata  = '0;   // start_req, line_level, zero fill
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;         // drive_enable, drive_level, busy_res, frame_done,
                                        // status[1:0], humidity_int, humidity_frac,
                                        // temp_int, temp_frac, zero fill
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [DATA_W-1:0] pwdata   = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int   errors;
    int   words_due;
    logic reader_busy;
    int   ticks;
    int   n_good;
    int   n_chksum;
    int   n_timeout;

    int cycles     = 0;
    int burst_left = 0;
    int ticks_sent = 0;
    int hold_asks  = 0;
    int setups     = 0;
    int cur_wake;
    int cur_start;
    int cur_release;
    int cur_one;
    int cur_to;

    single_wire_humidity_sensor_reader dut (.*);

    swhs_frame_checker u_checker (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("[single_wire_humidity_sensor_reader] ERROR");
            $finish;
        end
    end

    // result side: stall patterns in segments, plus a long hold on request
    initial
    begin : sink
        int holds_done;
        int seg;
        int mode;
        int i;
        holds_done = 0;
        forever
        begin
            if (hold_asks != holds_done)
            begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(8, 64);
            for (i = 0; i < seg; i++)
            begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 3) != 0);
                    2:       m_tready <= (i % 3 == 0);
                    default: m_tready <= 1'($urandom_range(0, 1));
                endcase
                @(posedge clk);
            end
        end
    end

    function automatic logic stray_req();
        return ($urandom_range(0, 7) == 0);
    endfunction

    task automatic send_tick(input logic req, input logic lv);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 5);
            repeat (gap)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W-2){1'b0}}, lv, req};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
        ticks_sent++;
    endtask

    task automatic send_noise(input int n, input bit allow_req);
        repeat (n)
            send_tick(allow_req ? logic'($urandom_range(0, 1)) : 1'b0,
                      logic'($urandom_range(0, 1)));
    endtask

    // finish any frame in flight by toggling the line, then wait for every result
    task automatic settle();
        logic lv;
        lv = 1'b1;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (reader_busy)
        begin
            send_tick(1'b0, lv);
            lv = ~lv;
        end
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (words_due != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_config(input int w, input int s, input int r, input int one,
                               input int to);
        apb_write(REG_WAKE, w);
        apb_write(REG_START, s);
        apb_write(REG_RELEASE, r);
        apb_write(REG_ONE, one);
        apb_write(REG_TIMEOUT, to);
        cur_wake    = w;
        cur_start   = s;
        cur_release = r;
        cur_one     = one;
        cur_to      = to;
        setups++;
    endtask

    // one sensor frame: response runs, then 40 pulses MSB first; optionally cut short,
    // ended by an over-long pulse, or stretched by a saturating pulse
    task automatic send_frame(input bit good_sum, input int cut_at, input int tmo_at,
                              input int long_at);
        logic [31:0] payload;
        logic [7:0]  chk;
        logic [39:0] frame;
        int          dur;
        int          h;
        int          lo;
        int          hi;
        int          i;
        payload = $urandom();
        chk     = payload[31:24] + payload[23:16] + payload[15:8] + payload[7:0];
        if (!good_sum)
            chk = chk ^ 8'(1 << $urandom_range(0, 7));
        frame = {payload, chk};
        dur = (cur_wake > 0 ? cur_wake : 1) + (cur_start > 0 ? cur_start : 1)
            + (cur_release > 0 ? cur_release : 1);

        send_tick(1'b1, 1'b1);
        repeat (dur) send_tick(stray_req(), 1'b1);
        repeat ($urandom_range(1, 3)) send_tick(stray_req(), 1'b1);
        repeat ($urandom_range(1, 4)) send_tick(stray_req(), 1'b0);
        repeat ($urandom_range(1, 4)) send_tick(stray_req(), 1'b1);
        repeat ($urandom_range(1, 2)) send_tick(stray_req(), 1'b0);

        for (i = 0; i < 40; i++)
        begin
            if (i == cut_at)
                return;
            if (i == tmo_at)
            begin
                repeat (cur_to + 1) send_tick(stray_req(), 1'b1);
                return;
            end
            if (i == long_at)
                h = 300;
            else
            begin
                if (frame[39-i] && cur_one < 255)
                begin
                    lo = cur_one + 1;
                    hi = cur_one + 2;
                    if (cur_to > cur_one && hi > cur_to)
                        hi = cur_to;
                end
                else
                begin
                    lo = 1;
                    hi = (cur_one < 1) ? 1 : ((cur_one > 3) ? 3 : cur_one);
                end
                h = $urandom_range(hi, lo);
            end
            repeat (h) send_tick(stray_req(), 1'b1);
            repeat ($urandom_range(1, 2)) send_tick(stray_req(), 1'b0);
        end
    endtask

    initial
    begin : stimulus
        int p;
        int pick;
        int mark;
        int long_at;
        int w;
        int s;
        int r;
        int one;
        int to;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle at reset timings; start stays low
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        settle();

        // zero drive counts and zero thresholds: start while busy, first released tick,
        // timeout on entry to the bit phase, timeout on the first high bit tick
        load_config(0, 0, 0, 0, 0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        settle();

        for (p = 0; p < 6; p++)
        begin
            w = $urandom_range(0, 6);
            s = $urandom_range(0, 6);
            r = $urandom_range(0, 6);
            case (p)
                0:
                begin
                    one = 0;
                    to  = $urandom_range(2, 4);
                end
                1:
                begin
                    one = 255;
                    to  = 255;
                    r   = 255;
                end
                default:
                begin
                    one = $urandom_range(1, 3);
                    to  = ($urandom_range(0, 3) == 0) ? 255 : one + $urandom_range(1, 4);
                end
            endcase
            load_config(w, s, r, one, to);
            if (p == 3)
                hold_asks++;
            long_at = (p == 1) ? $urandom_range(0, 39) : NO_BIT;
            mark = ticks_sent;
            while (ticks_sent - mark < PHASE_TICKS)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                begin
                    send_frame($urandom_range(0, 3) != 0, NO_BIT, NO_BIT, long_at);
                    long_at = NO_BIT;
                end
                else if (pick == 6)
                begin
                    send_frame(1'b1, $urandom_range(0, 39), NO_BIT, NO_BIT);
                    send_noise($urandom_range(5, 20), 1'b1);
                end
                else if (pick == 7 && cur_to < 255)
                    send_frame(1'b1, NO_BIT, $urandom_range(0, 39), NO_BIT);
                else
                    send_noise($urandom_range(5, 20), 1'b1);
            end
            settle();
        end

        // widest drive timings: idle traffic only
        load_config(20'hFFFFF, 16'hFFFF, $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255));
        send_noise(40, 1'b0);
        settle();
        repeat (8) @(posedge clk);

        $display("covered %0d tick words over %0d timing setups", ticks, setups);
        $display("frames ended: %0d good, %0d checksum errors, %0d timeouts",
                 n_good, n_chksum, n_timeout);
        if (errors == 0)
            $display("[single_wire_humidity_sensor_reader] OK");
        else
            $display("[single_wire_humidity_sensor_reader] ERROR");
        $finish;
    end

endmodule
